[src/cmnt_pkg.sv]
// Shared constants, types and width helpers for the cube map normal texel generator.
// No dependencies; every other file refers to it by scoped names.
package cmnt_pkg;

  localparam int unsigned FACE_SIZE_DEF = 32;
  localparam int unsigned FACE_W        = 3;
  localparam int unsigned COORD_W       = 5;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned QUO_W         = FRAC_W + 1;
  localparam int unsigned ONE_Q         = 1 << FRAC_W;
  localparam int unsigned MAG_W_DEF     = 7;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  // Per-item control that travels alongside the datapath.
  typedef struct packed {
    logic       valid;
    logic       bad;
    logic [2:0] neg;
  } ctl_t;

  // Bits for a component magnitude: |2i+1-N| and N both stay below N+64.
  function automatic int unsigned mag_w(input int unsigned n);
    return $clog2(n + 64);
  endfunction

endpackage

[src/cmnt_in_if.sv]
// Input channel: valid/ready handshake with face, column and row.
// Depends on cmnt_pkg for field widths.
interface cmnt_in_if;
  logic                         valid;
  logic                         ready;
  logic [cmnt_pkg::FACE_W-1:0]  face;
  logic [cmnt_pkg::COORD_W-1:0] column;
  logic [cmnt_pkg::COORD_W-1:0] row;

  modport source (output valid, output face, output column, output row, input ready);
  modport sink   (input valid, input face, input column, input row, output ready);
endinterface

[src/cmnt_out_if.sv]
// Result channel: valid/ready handshake with the red, green and blue bytes.
// Depends on cmnt_pkg for field widths.
interface cmnt_out_if;
  logic                        valid;
  logic                        ready;
  logic [cmnt_pkg::BYTE_W-1:0] red;
  logic [cmnt_pkg::BYTE_W-1:0] green;
  logic [cmnt_pkg::BYTE_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[src/cmnt_vec.sv]
// Front end: face decode to a direction vector, squares and squared length.
// Three register stages; depends on cmnt_pkg.
module cmnt_vec #(
  parameter int unsigned FACE_SIZE = cmnt_pkg::FACE_SIZE_DEF,
  parameter int unsigned MW        = cmnt_pkg::MAG_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ce,
  input  logic                               in_v,
  input  logic [cmnt_pkg::FACE_W-1:0]        face,
  input  logic [cmnt_pkg::COORD_W-1:0]       column,
  input  logic [cmnt_pkg::COORD_W-1:0]       row,
  output cmnt_pkg::ctl_t                     ctl_o,
  output logic [2:0][MW-1:0]                 mag_o,
  output logic [2*MW+1:0]                    len2_o
);

  localparam int unsigned SW = MW + 2;
  localparam int unsigned LW = 2 * MW + 2;

  logic signed [SW-1:0] s, t, nn;
  logic signed [SW-1:0] comp [3];
  logic                 bad;
  cmnt_pkg::ctl_t       ctl1_nxt;
  logic [2:0][MW-1:0]   mag1_nxt;

  cmnt_pkg::ctl_t       ctl1_r, ctl2_r, ctl3_r;
  logic [2:0][MW-1:0]   mag1_r, mag2_r, mag3_r;
  logic [2:0][2*MW-1:0] sq2_r;
  logic [LW-1:0]        len2_r;

  always_comb begin
    s   = $signed(SW'({column, 1'b1})) - $signed(SW'(FACE_SIZE));
    t   = $signed(SW'({row, 1'b1})) - $signed(SW'(FACE_SIZE));
    nn  = $signed(SW'(FACE_SIZE));
    bad = 1'b0;
    unique case (cmnt_pkg::face_t'(face))
      cmnt_pkg::FACE_PX: begin comp[0] = nn;  comp[1] = -t; comp[2] = -s; end
      cmnt_pkg::FACE_NX: begin comp[0] = -nn; comp[1] = -t; comp[2] = s;  end
      cmnt_pkg::FACE_PY: begin comp[0] = s;   comp[1] = nn; comp[2] = t;  end
      cmnt_pkg::FACE_NY: begin comp[0] = s;   comp[1] = -nn; comp[2] = -t; end
      cmnt_pkg::FACE_PZ: begin comp[0] = s;   comp[1] = -t; comp[2] = nn; end
      cmnt_pkg::FACE_NZ: begin comp[0] = -s;  comp[1] = -t; comp[2] = -nn; end
      default: begin
        // unused face codes: keep a harmless vector, zero the bytes later
        comp[0] = nn; comp[1] = '0; comp[2] = '0;
        bad     = 1'b1;
      end
    endcase
    ctl1_nxt.valid = in_v;
    ctl1_nxt.bad   = bad;
    for (int k = 0; k < 3; k++) begin
      ctl1_nxt.neg[k] = comp[k][SW-1];
      mag1_nxt[k]     = comp[k][SW-1] ? MW'(-comp[k]) : MW'(comp[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (ce) begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mag1_r <= mag1_nxt;
      mag2_r <= mag1_r;
      mag3_r <= mag2_r;
      for (int k = 0; k < 3; k++) begin
        sq2_r[k] <= mag1_r[k] * mag1_r[k];
      end
      len2_r <= LW'(sq2_r[0]) + LW'(sq2_r[1]) + LW'(sq2_r[2]);
    end
  end

  assign ctl_o  = ctl3_r;
  assign mag_o  = mag3_r;
  assign len2_o = len2_r;

endmodule

[src/cmnt_sqrt.sv]
// Pipelined integer square root of len2 * 2^32, one root bit per stage.
// Carries control and magnitudes alongside; depends on cmnt_pkg.
module cmnt_sqrt #(
  parameter int unsigned MW = cmnt_pkg::MAG_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  cmnt_pkg::ctl_t                ctl_i,
  input  logic [2:0][MW-1:0]            mag_i,
  input  logic [2*MW+1:0]               len2_i,
  output cmnt_pkg::ctl_t                ctl_o,
  output logic [2:0][MW-1:0]            mag_o,
  output logic [MW+cmnt_pkg::FRAC_W:0]  root_o
);

  localparam int unsigned LW  = 2 * MW + 2;
  localparam int unsigned QW  = MW + cmnt_pkg::FRAC_W + 1;
  localparam int unsigned RW  = 2 * QW;
  localparam int unsigned RMW = QW + 3;

  cmnt_pkg::ctl_t     ctl_r  [QW];
  logic [2:0][MW-1:0] mag_r  [QW];
  logic [LW-1:0]      len2_r [QW];
  logic [RMW-1:0]     rem_r  [QW];
  logic [QW-1:0]      root_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    cmnt_pkg::ctl_t     ctl_in;
    logic [2:0][MW-1:0] mag_in;
    logic [LW-1:0]      len2_in;
    logic [RMW-1:0]     rem_in, sh, trial, rem_nxt;
    logic [QW-1:0]      root_in, root_nxt;
    logic [RW-1:0]      rad;
    logic               ge;

    if (g == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign mag_in  = mag_i;
      assign len2_in = len2_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign ctl_in  = ctl_r[g-1];
      assign mag_in  = mag_r[g-1];
      assign len2_in = len2_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    always_comb begin
      rad      = {len2_in, {(2 * cmnt_pkg::FRAC_W){1'b0}}};
      sh       = {rem_in[RMW-3:0], rad[RW-1-2*g -: 2]};
      trial    = RMW'({root_in, 2'b01});
      ge       = (sh >= trial);
      rem_nxt  = ge ? (sh - trial) : sh;
      root_nxt = {root_in[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (ce) begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        mag_r[g]  <= mag_in;
        len2_r[g] <= len2_in;
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
      end
    end
  end

  assign ctl_o  = ctl_r[QW-1];
  assign mag_o  = mag_r[QW-1];
  assign root_o = root_r[QW-1];

endmodule

[src/cmnt_div.sv]
// Three-lane pipelined restoring divider: quotient = |c| * 2^32 / root (root = length in Q16).
// One quotient bit per stage, 17 stages; depends on cmnt_pkg.
module cmnt_div #(
  parameter int unsigned MW = cmnt_pkg::MAG_W_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  ce,
  input  cmnt_pkg::ctl_t                        ctl_i,
  input  logic [2:0][MW-1:0]                    mag_i,
  input  logic [MW+cmnt_pkg::FRAC_W:0]          root_i,
  output cmnt_pkg::ctl_t                        ctl_o,
  output logic [2:0][cmnt_pkg::QUO_W-1:0]       quo_o
);

  localparam int unsigned QW = MW + cmnt_pkg::FRAC_W + 1;
  localparam int unsigned DW = QW + 1;
  localparam int unsigned NS = cmnt_pkg::QUO_W;
  // top of the dividend lies above the quotient's reach
  localparam int unsigned PRE = 2 * cmnt_pkg::FRAC_W - NS;

  cmnt_pkg::ctl_t              ctl_r  [NS];
  logic [QW-1:0]               root_r [NS];
  logic [2:0][DW-1:0]          rem_r  [NS];
  logic [2:0][NS-1:0]          quo_r  [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    cmnt_pkg::ctl_t     ctl_in;
    logic [QW-1:0]      root_in;
    logic [2:0][DW-1:0] rem_in, rem_nxt;
    logic [2:0][NS-1:0] quo_in, quo_nxt;
    logic [DW-1:0]      sh;

    if (g == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign root_in = root_i;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_in[k] = DW'(mag_i[k]) << PRE;
      end
      assign quo_in = '0;
    end else begin : g_next
      assign ctl_in  = ctl_r[g-1];
      assign root_in = root_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quo_in  = quo_r[g-1];
    end

    always_comb begin
      sh = '0;
      for (int k = 0; k < 3; k++) begin
        sh = {rem_in[k][DW-2:0], 1'b0};
        if (sh >= DW'(root_in)) begin
          rem_nxt[k] = sh - DW'(root_in);
          quo_nxt[k] = {quo_in[k][NS-2:0], 1'b1};
        end else begin
          rem_nxt[k] = sh;
          quo_nxt[k] = {quo_in[k][NS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (ce) begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        root_r[g] <= root_in;
        rem_r[g]  <= rem_nxt;
        quo_r[g]  <= quo_nxt;
      end
    end
  end

  assign ctl_o = ctl_r[NS-1];
  assign quo_o = quo_r[NS-1];

endmodule

[src/cube_map_normal_texel_generator.sv]
// Top level of the cube map normal texel generator: pipeline plus output skid.
// Depends on cmnt_pkg, cmnt_in_if, cmnt_out_if, cmnt_vec, cmnt_sqrt and cmnt_div.
// One texel enters per clock while in_ch.ready is high, and one RGB result
// leaves per clock while out_ch.ready is high. An accepted item passes through
// the front-end registers, the square root pipeline (one root bit a stage), the
// divider pipeline (one quotient bit a stage) and the output register. A stalled
// output is absorbed by a two-entry output buffer; in_ch.ready drops only once
// both entries are full.
module cube_map_normal_texel_generator #(
  parameter int unsigned FACE_SIZE = cmnt_pkg::FACE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cmnt_in_if.sink     in_ch,
  cmnt_out_if.source  out_ch
);

  localparam int unsigned MW  = cmnt_pkg::mag_w(FACE_SIZE);
  localparam int unsigned QW  = MW + cmnt_pkg::FRAC_W + 1;
  localparam int unsigned VW  = cmnt_pkg::QUO_W + 1;
  localparam int unsigned PW  = VW + cmnt_pkg::BYTE_W;
  localparam int unsigned BW  = cmnt_pkg::BYTE_W;

  logic                               ce;
  cmnt_pkg::ctl_t                     vec_ctl, sq_ctl, div_ctl;
  logic [2:0][MW-1:0]                 vec_mag, sq_mag;
  logic [2*MW+1:0]                    vec_len2;
  logic [QW-1:0]                      sq_root;
  logic [2:0][cmnt_pkg::QUO_W-1:0]    div_quo;

  logic [2:0][BW-1:0]                 pix;
  logic [2:0][BW-1:0]                 out_r, out_nxt, skid_r, skid_nxt;
  logic                               out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic                               emit;

  assign ce          = !skid_v_r;
  assign in_ch.ready = ce;

  cmnt_vec #(.FACE_SIZE(FACE_SIZE), .MW(MW)) u_vec (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .in_v   (in_ch.valid),
    .face   (in_ch.face),
    .column (in_ch.column),
    .row    (in_ch.row),
    .ctl_o  (vec_ctl),
    .mag_o  (vec_mag),
    .len2_o (vec_len2)
  );

  cmnt_sqrt #(.MW(MW)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .ctl_i  (vec_ctl),
    .mag_i  (vec_mag),
    .len2_i (vec_len2),
    .ctl_o  (sq_ctl),
    .mag_o  (sq_mag),
    .root_o (sq_root)
  );

  cmnt_div #(.MW(MW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .ctl_i  (sq_ctl),
    .mag_i  (sq_mag),
    .root_i (sq_root),
    .ctl_o  (div_ctl),
    .quo_o  (div_quo)
  );

  // Map the signed Q16 component to a byte: floor((n + 1.0) * 255 / 2).
  always_comb begin
    logic [cmnt_pkg::QUO_W-1:0] q;
    logic [VW-1:0]              v;
    logic [PW-1:0]              p;
    q = '0;
    v = '0;
    p = '0;
    for (int k = 0; k < 3; k++) begin
      q = (div_quo[k] > cmnt_pkg::QUO_W'(cmnt_pkg::ONE_Q)) ?
          cmnt_pkg::QUO_W'(cmnt_pkg::ONE_Q) : div_quo[k];
      v = div_ctl.neg[k] ? (VW'(cmnt_pkg::ONE_Q) - VW'(q)) : (VW'(cmnt_pkg::ONE_Q) + VW'(q));
      p = (PW'(v) << BW) - PW'(v);
      pix[k] = div_ctl.bad ? '0 : p[VW+BW-2 -: BW];
    end
  end

  assign emit = ce && div_ctl.valid;

  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (out_v_r && out_ch.ready) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else if (emit) begin
        out_nxt = pix;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (!out_v_r) begin
      if (emit) begin
        out_nxt   = pix;
        out_v_nxt = 1'b1;
      end
    end else if (emit) begin
      // output held: park the item
      skid_nxt   = pix;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.red   = out_r[0];
  assign out_ch.green = out_r[1];
  assign out_ch.blue  = out_r[2];

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without an output item");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ch.ready |=> skid_v_r)
    else $error("parked item dropped while output stalled");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled while output was free");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(div_ctl))
    else $error("pipeline moved while output buffer full");

endmodule
